>>> rtl/touch_sample_map_and_press_detect_unit_assert.svh
// Assertion macros for the touch sample map and press detect unit.
`ifndef TOUCH_SAMPLE_MAP_AND_PRESS_DETECT_UNIT_ASSERT_SVH
`define TOUCH_SAMPLE_MAP_AND_PRESS_DETECT_UNIT_ASSERT_SVH

// Checks a condition at every clock edge outside reset.
`define TSMPD_ASSERT_ALWAYS(label, ck, rstn, expr, msg) \
	label: assert property (@(posedge ck) disable iff (!rstn) (expr)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define TSMPD_ASSERT_NEXT(label, ck, rstn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/tsmpd_pkg.sv
// Shared types and constants of the touch sample map and press detect unit.
package tsmpd_pkg;

	localparam int RAW_W     = 10;
	localparam int CRD_W     = 12;
	localparam int DIFF_W    = RAW_W + 1;
	localparam int DVD_W     = RAW_W + CRD_W;
	localparam int DIV_STEPS = DVD_W;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);
	localparam int IDX_W     = 3;

	localparam logic [IDX_W-1:0] REG_X_CAL_LOW  = 3'd0;
	localparam logic [IDX_W-1:0] REG_X_CAL_HIGH = 3'd1;
	localparam logic [IDX_W-1:0] REG_Y_CAL_LOW  = 3'd2;
	localparam logic [IDX_W-1:0] REG_Y_CAL_HIGH = 3'd3;
	localparam logic [IDX_W-1:0] REG_X_SPAN     = 3'd4;
	localparam logic [IDX_W-1:0] REG_Y_SPAN     = 3'd5;
	localparam logic [IDX_W-1:0] REG_DEAD_ZONE  = 3'd6;

	localparam logic [RAW_W-1:0] RST_X_CAL_LOW  = 10'd90;
	localparam logic [RAW_W-1:0] RST_X_CAL_HIGH = 10'd950;
	localparam logic [RAW_W-1:0] RST_Y_CAL_LOW  = 10'd100;
	localparam logic [RAW_W-1:0] RST_Y_CAL_HIGH = 10'd860;
	localparam logic [CRD_W-1:0] RST_X_SPAN     = 12'd1000;
	localparam logic [CRD_W-1:0] RST_Y_SPAN     = 12'd1000;
	localparam logic [CRD_W-1:0] RST_DEAD_ZONE  = 12'd5;

	typedef struct packed {
		logic [RAW_W-1:0] x_cal_low;
		logic [RAW_W-1:0] x_cal_high;
		logic [RAW_W-1:0] y_cal_low;
		logic [RAW_W-1:0] y_cal_high;
		logic [CRD_W-1:0] x_span;
		logic [CRD_W-1:0] y_span;
		logic [CRD_W-1:0] dead_zone;
	} cfg_t;

endpackage

>>> rtl/touch_sample_map_and_press_detect_unit.sv
// Top level: touch sample mapper and press detector with a shared divider.
//
//  Channel | Direction | Signals                         | Word
//  s_      | in        | s_tvalid s_tready s_tdata s_tuser | one raw sample pair
//  m_      | out       | m_tvalid m_tready m_tdata m_tuser | mapped pair and flags
//  cfg_    | in        | cfg_valid cfg_ready cfg_index cfg_data | one register write
//
// A result word passes these steps after acceptance: per axis a multiply state, a divider
// load, 22 restoring steps, the done strobe and a clamp state, then the decide state; the
// shared divider runs x and y in turn, and decide waits while the output register is full.
// The input side is ready only while the sequencer is idle; a finished word waits
// in the output register, and the next sample may be accepted meanwhile.
// Reset clears the sequencer, the rest reference and the held button state.
`include "touch_sample_map_and_press_detect_unit_assert.svh"

module touch_sample_map_and_press_detect_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [23:0]                 s_tdata,   // raw_x [9:0], raw_y [19:10], zero pad
	input  logic [0:0]                  s_tuser,   // capture_rest [0]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [23:0]                 m_tdata,   // coord_x [11:0], coord_y [23:12]
	output logic [1:0]                  m_tuser,   // press_active [0], release_now [1]
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tsmpd_pkg::IDX_W-1:0] cfg_index,
	input  logic [tsmpd_pkg::CRD_W-1:0] cfg_data
);
	import tsmpd_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_MUL    = 6'b000010,
		ST_LOAD   = 6'b000100,
		ST_DIV    = 6'b001000,
		ST_CLAMP  = 6'b010000,
		ST_DECIDE = 6'b100000
	} state_t;

	state_t           state_q;
	cfg_t             cfg;

	logic [RAW_W-1:0] raw_x_q, raw_y_q;
	logic             capture_q;
	logic             axis_q;
	logic [DVD_W-1:0] prod_q;
	logic [RAW_W-1:0] den_mag_q;
	logic             zero_q;
	logic [CRD_W-1:0] coord_x_q, coord_y_q;
	logic [CRD_W-1:0] rest_x_q, rest_y_q;
	logic             held_q;

	logic             m_valid_q;
	logic [CRD_W-1:0] m_x_q, m_y_q;
	logic             m_press_q, m_release_q;

	logic [RAW_W-1:0] raw_sel, lo_sel, hi_sel;
	logic [CRD_W-1:0] span_sel;
	logic [DIFF_W-1:0] diff, den;
	logic [RAW_W-1:0] diff_mag, den_mag;
	logic [DVD_W-1:0] prod;
	logic             div_start, div_done;
	logic [DVD_W-1:0] quot;
	logic [CRD_W-1:0] clamped;
	logic [CRD_W-1:0] adx, ady;
	logic             is_press, is_release;
	logic             out_free, in_acc, load_out;

	tsmpd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	tsmpd_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (den_mag_q),
		.done     (div_done),
		.quotient (quot)
	);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;
	assign load_out  = (state_q == ST_DECIDE) && out_free;
	assign div_start = (state_q == ST_LOAD);

	always_comb begin
		raw_sel  = axis_q ? raw_y_q : raw_x_q;
		lo_sel   = axis_q ? cfg.y_cal_low : cfg.x_cal_low;
		hi_sel   = axis_q ? cfg.y_cal_high : cfg.x_cal_high;
		span_sel = axis_q ? cfg.y_span : cfg.x_span;
	end

	// The signed quotient is negative or zero when the signs differ, so the clamp
	// leaves zero; otherwise magnitudes divide unsigned.
	assign diff     = {1'b0, raw_sel} - {1'b0, lo_sel};
	assign den      = {1'b0, hi_sel} - {1'b0, lo_sel};
	assign diff_mag = diff[DIFF_W-1] ? RAW_W'(-diff) : diff[RAW_W-1:0];
	assign den_mag  = den[DIFF_W-1] ? RAW_W'(-den) : den[RAW_W-1:0];
	assign prod     = {{CRD_W{1'b0}}, diff_mag} * {{RAW_W{1'b0}}, span_sel};

	assign clamped = zero_q ? '0 :
		(quot > {{RAW_W{1'b0}}, span_sel}) ? span_sel : quot[CRD_W-1:0];

	assign adx = (coord_x_q > rest_x_q) ? coord_x_q - rest_x_q : rest_x_q - coord_x_q;
	assign ady = (coord_y_q > rest_y_q) ? coord_y_q - rest_y_q : rest_y_q - coord_y_q;
	assign is_press   = !capture_q && (adx > cfg.dead_zone) && (ady > cfg.dead_zone);
	assign is_release = !capture_q && !is_press && held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			axis_q    <= 1'b0;
			rest_x_q  <= '0;
			rest_y_q  <= '0;
			held_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						axis_q  <= 1'b0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_LOAD;
				ST_LOAD: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					if (!axis_q) begin
						axis_q  <= 1'b1;
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (out_free) begin
						if (capture_q) begin
							rest_x_q <= coord_x_q;
							rest_y_q <= coord_y_q;
						end else if (is_press) begin
							held_q <= 1'b1;
						end else if (is_release) begin
							held_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			raw_x_q   <= s_tdata[RAW_W-1:0];
			raw_y_q   <= s_tdata[2*RAW_W-1:RAW_W];
			capture_q <= s_tuser[0];
		end
		if (state_q == ST_MUL) begin
			prod_q    <= prod;
			den_mag_q <= den_mag;
			zero_q    <= (den == '0) || (diff[DIFF_W-1] != den[DIFF_W-1]);
		end
		if (state_q == ST_CLAMP) begin
			if (!axis_q) begin
				coord_x_q <= clamped;
			end else begin
				coord_y_q <= clamped;
			end
		end
		if (load_out) begin
			m_x_q       <= coord_x_q;
			m_y_q       <= coord_y_q;
			m_press_q   <= is_press;
			m_release_q <= is_release;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_y_q, m_x_q};
	assign m_tuser  = {m_release_q, m_press_q};

	`TSMPD_ASSERT_ALWAYS(a_flags_exclusive, clk, arst_n, !(m_valid_q && m_press_q && m_release_q), "press and release reported together")
	`TSMPD_ASSERT_ALWAYS(a_coord_clamped, clk, arst_n, !m_valid_q || (m_x_q <= cfg.x_span && m_y_q <= cfg.y_span), "coordinate above span")
	`TSMPD_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_acc, !s_tready, "input ready while a sample is in work")
	`TSMPD_ASSERT_ALWAYS(a_div_done_in_div, clk, arst_n, !div_done || state_q == ST_DIV, "divider finished outside the divide step")

endmodule

>>> rtl/tsmpd_cfg_regs.sv
// Calibration and dead zone register file.
module tsmpd_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [tsmpd_pkg::IDX_W-1:0] wr_index,
	input  logic [tsmpd_pkg::CRD_W-1:0] wr_data,
	output tsmpd_pkg::cfg_t             cfg
);
	import tsmpd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_cal_low  <= RST_X_CAL_LOW;
			cfg_q.x_cal_high <= RST_X_CAL_HIGH;
			cfg_q.y_cal_low  <= RST_Y_CAL_LOW;
			cfg_q.y_cal_high <= RST_Y_CAL_HIGH;
			cfg_q.x_span     <= RST_X_SPAN;
			cfg_q.y_span     <= RST_Y_SPAN;
			cfg_q.dead_zone  <= RST_DEAD_ZONE;
		end else if (wr_en) begin
			case (wr_index)
				REG_X_CAL_LOW:  cfg_q.x_cal_low  <= wr_data[RAW_W-1:0];
				REG_X_CAL_HIGH: cfg_q.x_cal_high <= wr_data[RAW_W-1:0];
				REG_Y_CAL_LOW:  cfg_q.y_cal_low  <= wr_data[RAW_W-1:0];
				REG_Y_CAL_HIGH: cfg_q.y_cal_high <= wr_data[RAW_W-1:0];
				REG_X_SPAN:     cfg_q.x_span     <= wr_data;
				REG_Y_SPAN:     cfg_q.y_span     <= wr_data;
				REG_DEAD_ZONE:  cfg_q.dead_zone  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/tsmpd_divider.sv
// Restoring divider, one quotient bit per cycle, shared by both axes.
module tsmpd_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tsmpd_pkg::DVD_W-1:0] dividend,
	input  logic [tsmpd_pkg::RAW_W-1:0] divisor,
	output logic                        done,
	output logic [tsmpd_pkg::DVD_W-1:0] quotient
);
	import tsmpd_pkg::*;

	logic [DVD_W-1:0] quo_q;
	logic [RAW_W-1:0] rem_q;
	logic [RAW_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	logic [RAW_W:0]   shifted;
	logic [RAW_W+1:0] trial;
	logic             fits;

	// The remainder stays below the divisor, so the shifted value fits in one extra bit.
	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dsr_q};
	assign fits    = !trial[RAW_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DIV_STEPS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? trial[RAW_W-1:0] : shifted[RAW_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
